/* sv/rme_pkg.sv */
// shared types, constants and helper functions for the rotation matrix to euler block
package rme_pkg;

  localparam int MW       = 16;
  localparam int OPW      = 17;
  localparam int CW       = 32;
  localparam int ZW       = 28;
  localparam int AW       = 16;
  localparam int SQW      = 32;
  localparam int SQ_STAGES = 8;

  localparam logic signed [ZW-1:0] HALF_PI_Q24 = 28'sd26353589;
  localparam logic signed [AW-1:0] PI_Q13      = 16'sd25736;

  typedef struct packed {
    logic signed [MW-1:0] m00;
    logic signed [MW-1:0] m10;
    logic signed [MW-1:0] m20;
    logic signed [MW-1:0] m21;
    logic signed [MW-1:0] m22;
    logic signed [MW-1:0] m11;
    logic signed [MW-1:0] m12;
  } mat_t;

  typedef struct packed {
    logic [SQW-1:0] v;
    logic [SQW:0]   r;
  } sq_t;

  typedef struct packed {
    logic zero;
    logic negx;
  } spec_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 28'sd13176795;
      1:  a = 28'sd7778716;
      2:  a = 28'sd4110060;
      3:  a = 28'sd2086331;
      4:  a = 28'sd1047214;
      5:  a = 28'sd524117;
      6:  a = 28'sd262123;
      7:  a = 28'sd131069;
      8:  a = 28'sd65536;
      9:  a = 28'sd32768;
      10: a = 28'sd16384;
      11: a = 28'sd8192;
      12: a = 28'sd4096;
      13: a = 28'sd2048;
      14: a = 28'sd1024;
      15: a = 28'sd512;
      16: a = 28'sd256;
      17: a = 28'sd128;
      18: a = 28'sd64;
      19: a = 28'sd32;
      20: a = 28'sd16;
      21: a = 28'sd8;
      22: a = 28'sd4;
      23: a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

  // one restoring square root step
  function automatic sq_t sqrt_step(input sq_t s, input logic [SQW:0] b);
    sq_t o;
    logic [SQW+1:0] t;
    t = {1'b0, s.r} + {1'b0, b};
    if ({2'b00, s.v} >= t) begin
      o.v = s.v - t[SQW-1:0];
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

endpackage

/* sv/rme_sqrt.sv */
// pipelined sum of squares and integer square root, matrix carried alongside
module rme_sqrt import rme_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mat_t            mat_i,
  output logic            valid_o,
  output mat_t            mat_o,
  output logic [MW-1:0]   sy_o
);

  localparam int LAST = 1 + SQ_STAGES;

  logic                  vld_q [0:LAST];
  mat_t                  mat_q [0:LAST];
  logic signed [SQW-1:0] sqa_q, sqb_q;
  sq_t                   sq_q  [1:LAST];
  logic signed [SQW-1:0] prod_a, prod_b;

  assign prod_a = mat_i.m00 * mat_i.m00;
  assign prod_b = mat_i.m10 * mat_i.m10;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= LAST; k++) vld_q[k] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= LAST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q[0] <= mat_i;
      for (int k = 1; k <= LAST; k++) mat_q[k] <= mat_q[k-1];
      sqa_q <= prod_a;
      sqb_q <= prod_b;
      sq_q[1].v <= sqa_q + sqb_q;
      sq_q[1].r <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES - 1; k++) begin : g_root
    localparam logic [SQW:0] B0 = (SQW+1)'(1) << (30 - 4*k);
    localparam logic [SQW:0] B1 = (SQW+1)'(1) << (28 - 4*k);
    sq_t nxt;
    always_comb begin
      nxt = sqrt_step(sqrt_step(sq_q[k+1], B0), B1);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) sq_q[k+2] <= nxt;
    end
  end

  // last two steps finish in the output register
  sq_t fin;
  always_comb begin
    fin = sqrt_step(sqrt_step(sq_q[LAST-1], (SQW+1)'(4)), (SQW+1)'(1));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) sq_q[LAST] <= fin;
  end

  assign valid_o = vld_q[LAST];
  assign mat_o   = mat_q[LAST];
  assign sy_o    = sq_q[LAST].r[MW-1:0];

endmodule

/* sv/rme_cordic.sv */
// pipelined vectoring cordic atan2 with quadrant fold, rounding and saturation
module rme_cordic import rme_pkg::*; #(
  parameter int STAGES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [OPW-1:0] y_i,
  input  logic signed [OPW-1:0] x_i,
  output logic                  valid_o,
  output logic signed [AW-1:0]  angle_o
);

  logic                 vld_q  [0:STAGES];
  spec_t                spec_q [0:STAGES];
  logic signed [CW-1:0] x_q    [0:STAGES];
  logic signed [CW-1:0] y_q    [0:STAGES];
  logic signed [ZW-1:0] z_q    [0:STAGES];
  logic                 vld_out_q;
  logic signed [AW-1:0] angle_q;

  logic signed [CW-1:0] xs, ys, x_d, y_d;
  logic signed [ZW-1:0] z_d;
  spec_t                spec_d;

  // fold the left half plane onto the right one
  always_comb begin
    xs = CW'(x_i) <<< 12;
    ys = CW'(y_i) <<< 12;
    spec_d.zero = (y_i == '0);
    spec_d.negx = x_i[OPW-1];
    if (x_i[OPW-1]) begin
      if (!y_i[OPW-1]) begin
        x_d = ys;
        y_d = -xs;
        z_d = HALF_PI_Q24;
      end else begin
        x_d = -ys;
        y_d = xs;
        z_d = -HALF_PI_Q24;
      end
    end else begin
      x_d = xs;
      y_d = ys;
      z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= STAGES; k++) vld_q[k] <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= STAGES; k++) vld_q[k] <= vld_q[k-1];
      vld_out_q <= vld_q[STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x_d;
      y_q[0]    <= y_d;
      z_q[0]    <= z_d;
      spec_q[0] <= spec_d;
      for (int k = 1; k <= STAGES; k++) spec_q[k] <= spec_q[k-1];
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = atan_q24(i);
    logic signed [CW-1:0] ysh, xsh;
    assign ysh = y_q[i] >>> i;
    assign xsh = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - ysh;
          y_q[i+1] <= y_q[i] + xsh;
          z_q[i+1] <= z_q[i] - ANG;
        end else begin
          x_q[i+1] <= x_q[i] + ysh;
          y_q[i+1] <= y_q[i] - xsh;
          z_q[i+1] <= z_q[i] + ANG;
        end
      end
    end
  end

  // round to q3.13 and clamp to plus or minus pi; a zero y gives 0, or pi when x is negative
  logic signed [ZW-1:0]    zr;
  logic signed [ZW-12:0]   zs;
  logic signed [AW-1:0]    angle_d;
  always_comb begin
    zr = z_q[STAGES] + ZW'(1024);
    zs = zr[ZW-1:11];
    if (spec_q[STAGES].zero) begin
      angle_d = spec_q[STAGES].negx ? PI_Q13 : '0;
    end else if (zs > (ZW-11)'(PI_Q13)) begin
      angle_d = PI_Q13;
    end else if (zs < -(ZW-11)'(PI_Q13)) begin
      angle_d = -PI_Q13;
    end else begin
      angle_d = zs[AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) angle_q <= angle_d;
  end

  assign valid_o = vld_out_q;
  assign angle_o = angle_q;

endmodule

/* sv/rotation_matrix_to_euler.sv */
// top level: rotation matrix to xyz euler angles with apb threshold register
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  input    | in_valid_i / in_ready_o    | m00_i m10_i m20_i m21_i m22_i m11_i m12_i
//  output   | out_valid_o / out_ready_i  | roll/pitch/yaw_angle_o is_singular_o
//  config   | psel/penable/pwrite/pready | paddr_i pwdata_i prdata_o
//
// one request per cycle while the output register is free or taken; a request
// passes the squaring and square root, the operand select register, then the cordic;
// the square root takes two result bits per stage and the cordic one iteration
// per stage; all stages advance together whenever the output register is free
// or taken, so a stall holds every stage in place
// reset clears all valid bits and sets the threshold to 1
module rotation_matrix_to_euler import rme_pkg::*; #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [MW-1:0] m00_i,
  input  logic signed [MW-1:0] m10_i,
  input  logic signed [MW-1:0] m20_i,
  input  logic signed [MW-1:0] m21_i,
  input  logic signed [MW-1:0] m22_i,
  input  logic signed [MW-1:0] m11_i,
  input  logic signed [MW-1:0] m12_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [AW-1:0] roll_angle_o,
  output logic signed [AW-1:0] pitch_angle_o,
  output logic signed [AW-1:0] yaw_angle_o,
  output logic                 is_singular_o,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [2:0]           paddr_i,
  input  logic [31:0]          pwdata_i,
  output logic [31:0]          prdata_o,
  output logic                 pready_o
);

  localparam logic REG_THRESHOLD = 1'b0;
  localparam int   SLAST = CORDIC_STAGES + 2;

  logic        en;
  logic [14:0] thr_q;

  mat_t          mat_in, mat_s;
  logic          vld_s;
  logic [MW-1:0] sy_s;

  logic                  sel_v_q;
  logic signed [OPW-1:0] roll_y_q, roll_x_q, pitch_y_q, pitch_x_q, yaw_y_q, yaw_x_q;
  logic                  sing_q [0:SLAST];
  logic                  sing;

  logic signed [AW-1:0] roll_a, pitch_a, yaw_a;

  function automatic logic signed [OPW-1:0] neg_ext(input logic signed [MW-1:0] a);
    return -OPW'(a);
  endfunction

  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;
  assign pready_o   = 1'b1;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 15'd1;
    end else if (psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_THRESHOLD)) begin
      thr_q <= pwdata_i[14:0];
    end
  end

  assign prdata_o = (paddr_i[2] == REG_THRESHOLD) ? {17'd0, thr_q} : 32'd0;

  assign mat_in = '{m00: m00_i, m10: m10_i, m20: m20_i, m21: m21_i,
                    m22: m22_i, m11: m11_i, m12: m12_i};

  rme_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mat_i   (mat_in),
    .valid_o (vld_s),
    .mat_o   (mat_s),
    .sy_o    (sy_s)
  );

  assign sing = ({1'b0, sy_s} < {2'b00, thr_q});

  // operand select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
      for (int k = 0; k <= SLAST; k++) sing_q[k] <= 1'b0;
    end else if (en) begin
      sel_v_q   <= vld_s;
      sing_q[0] <= sing;
      for (int k = 1; k <= SLAST; k++) sing_q[k] <= sing_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pitch_y_q <= neg_ext(mat_s.m20);
      pitch_x_q <= OPW'(sy_s);
      yaw_y_q   <= OPW'(mat_s.m10);
      yaw_x_q   <= OPW'(mat_s.m00);
      if (sing) begin
        roll_y_q <= neg_ext(mat_s.m12);
        roll_x_q <= OPW'(mat_s.m11);
      end else begin
        roll_y_q <= OPW'(mat_s.m21);
        roll_x_q <= OPW'(mat_s.m22);
      end
    end
  end

  rme_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (sel_v_q),
    .y_i (roll_y_q), .x_i (roll_x_q), .valid_o (), .angle_o (roll_a)
  );

  rme_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (sel_v_q),
    .y_i (pitch_y_q), .x_i (pitch_x_q), .valid_o (out_valid_o), .angle_o (pitch_a)
  );

  rme_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (sel_v_q),
    .y_i (yaw_y_q), .x_i (yaw_x_q), .valid_o (), .angle_o (yaw_a)
  );

  assign roll_angle_o  = roll_a;
  assign pitch_angle_o = pitch_a;
  assign is_singular_o = sing_q[SLAST];
  assign yaw_angle_o   = sing_q[SLAST] ? '0 : yaw_a;

endmodule
